// File: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Field widths, status codes and the bitmap row layout of the allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int unsigned HEAP_UNITS_DEF = 1024;

	localparam int ROW_BITS = 16;
	localparam int ROW_IW   = 4;

	localparam int REQ_W   = 11;
	localparam int START_W = 10;
	localparam int LEN_W   = 11;
	localparam int STAT_W  = 2;
	localparam int GRANT_W = 10;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_FIT  = 2'd1;
	localparam status_t ST_UNKNOWN = 2'd2;
	localparam status_t ST_ZERO    = 2'd3;

	typedef struct packed {
		logic [ROW_BITS-1:0] head;
		logic [ROW_BITS-1:0] free;
	} row_t;

endpackage

// File: sv/first_fit_allocator.sv
// ----------------------------------------------------------------------------
// First-fit allocator
// Allocate: scan rows of 16 units from row 0 to the row where the first
// fitting run ends (at most ceil(HEAP_UNITS/16) rows), then mark each row the
// block spans. Free: read the row and length, check the head, then free each
// row spanned. busy covers each item not rejected on acceptance; the
// done strobe rises as busy falls. A clearing pass after reset holds busy high.
// ----------------------------------------------------------------------------
module first_fit_allocator #(
	parameter int unsigned HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         kind,
	input  logic [ffa_pkg::REQ_W-1:0]    request_units,
	input  logic [ffa_pkg::START_W-1:0]  block_start,
	output logic                         done,
	output ffa_pkg::status_t             status,
	output logic [ffa_pkg::GRANT_W-1:0]  granted_start
);

	import ffa_pkg::*;

	localparam int AW    = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
	localparam int ROWS  = (HEAP_UNITS + ROW_BITS - 1) / ROW_BITS;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RUN_W = LEN_W + 1;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FCHK = 3'd3;
	localparam logic [2:0] S_MARK = 3'd4;

	logic [2:0]         state_q;
	logic [RW-1:0]      init_q;
	logic [RW-1:0]      ev_row_q;
	logic [RW-1:0]      mark_row_q;
	logic [LEN_W-1:0]   run_q;
	logic [LEN_W-1:0]   want_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic               fill_q;
	logic               done_q;
	status_t            status_q;
	logic [GRANT_W-1:0] granted_q;

	row_t               bmp_mem [ROWS];
	logic [LEN_W-1:0]   len_mem [HEAP_UNITS];

	logic               bm_rd;
	logic [RW-1:0]      bm_raddr;
	row_t               bm_rdata_q;
	logic               bm_wr;
	logic [RW-1:0]      bm_waddr;
	row_t               bm_wdata;
	logic               len_rd;
	logic [AW-1:0]      len_raddr;
	logic [LEN_W-1:0]   len_rdata_q;
	logic               len_wr;

	logic               hit;
	logic [ROW_IW-1:0]  hit_idx;
	logic [LEN_W-1:0]   run_next;
	logic [AW-1:0]      hit_lo;
	logic [AW-1:0]      hit_hi;
	logic               scan_last;
	logic               mark_last;
	row_t               init_row;
	row_t               mod_row;
	logic [AW-1:0]      start_u;

	function automatic logic [RW-1:0] row_of(input logic [AW-1:0] u);
		return RW'(u >> ROW_IW);
	endfunction

	assign start_u   = AW'(block_start);
	assign scan_last = (ev_row_q == RW'(ROWS - 1));
	assign mark_last = (mark_row_q == row_of(hi_q));

	// run length ending at each unit of the row under scan
	always_comb begin
		logic             seen0;
		int               hz;
		logic [RUN_W-1:0] len_b;
		hit      = 1'b0;
		hit_idx  = '0;
		run_next = '0;
		for (int b = 0; b < ROW_BITS; b++) begin
			seen0 = 1'b0;
			hz    = 0;
			for (int k = 0; k < ROW_BITS; k++) begin
				if (k <= b && !bm_rdata_q.free[k]) begin
					seen0 = 1'b1;
					hz    = k;
				end
			end
			len_b = seen0 ? RUN_W'(b - hz) : (RUN_W'(run_q) + RUN_W'(b + 1));
			if (!hit && bm_rdata_q.free[b] && len_b >= {1'b0, want_q}) begin
				hit     = 1'b1;
				hit_idx = ROW_IW'(b);
			end
			if (b == ROW_BITS - 1) begin
				run_next = LEN_W'(len_b);
			end
		end
	end

	assign hit_hi = AW'(32'(ev_row_q) * ROW_BITS + 32'(hit_idx));
	assign hit_lo = AW'(32'(ev_row_q) * ROW_BITS + 32'(hit_idx) + 1 - 32'(want_q));

	always_comb begin
		init_row = '0;
		for (int b = 0; b < ROW_BITS; b++) begin
			init_row.free[b] = (32'(init_q) * ROW_BITS + b) < 32'(HEAP_UNITS);
		end
	end

	always_comb begin
		logic [31:0] u;
		mod_row = bm_rdata_q;
		for (int b = 0; b < ROW_BITS; b++) begin
			u = 32'(mark_row_q) * ROW_BITS + b;
			if (u >= 32'(lo_q) && u <= 32'(hi_q)) begin
				mod_row.free[b] = fill_q;
			end
			if (u == 32'(lo_q)) begin
				mod_row.head[b] = !fill_q;
			end
		end
	end

	always_comb begin
		bm_rd     = 1'b0;
		bm_raddr  = '0;
		bm_wr     = 1'b0;
		bm_waddr  = '0;
		bm_wdata  = '0;
		len_rd    = 1'b0;
		len_raddr = start_u;
		len_wr    = 1'b0;
		case (state_q)
			S_INIT: begin
				bm_wr    = 1'b1;
				bm_waddr = init_q;
				bm_wdata = init_row;
			end
			S_IDLE: begin
				if (start) begin
					bm_rd = 1'b1;
					if (kind) begin
						bm_raddr = row_of(start_u);
						len_rd   = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					bm_rd    = 1'b1;
					bm_raddr = row_of(hit_lo);
				end else if (!scan_last) begin
					bm_rd    = 1'b1;
					bm_raddr = ev_row_q + 1'b1;
				end
			end
			S_MARK: begin
				bm_wr    = 1'b1;
				bm_waddr = mark_row_q;
				bm_wdata = mod_row;
				len_wr   = !fill_q;
				if (!mark_last) begin
					bm_rd    = 1'b1;
					bm_raddr = mark_row_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_wr) begin
			bmp_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_rd) begin
			bm_rdata_q <= bmp_mem[bm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (len_wr) begin
			len_mem[lo_q] <= want_q;
		end
		if (len_rd) begin
			len_rdata_q <= len_mem[len_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			init_q    <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			granted_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					if (init_q == RW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						init_q <= init_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						want_q <= request_units;
						lo_q   <= start_u;
						if (!kind) begin
							if (request_units == '0) begin
								done_q    <= 1'b1;
								status_q  <= ST_ZERO;
								granted_q <= '0;
							end else if (32'(request_units) > 32'(HEAP_UNITS)) begin
								done_q    <= 1'b1;
								status_q  <= ST_NO_FIT;
								granted_q <= '0;
							end else begin
								ev_row_q <= '0;
								run_q    <= '0;
								state_q  <= S_SCAN;
							end
						end else begin
							if (32'(block_start) >= 32'(HEAP_UNITS)) begin
								done_q    <= 1'b1;
								status_q  <= ST_UNKNOWN;
								granted_q <= '0;
							end else begin
								state_q <= S_FCHK;
							end
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						lo_q       <= hit_lo;
						hi_q       <= hit_hi;
						fill_q     <= 1'b0;
						mark_row_q <= row_of(hit_lo);
						state_q    <= S_MARK;
					end else if (scan_last) begin
						done_q    <= 1'b1;
						status_q  <= ST_NO_FIT;
						granted_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						ev_row_q <= ev_row_q + 1'b1;
						run_q    <= run_next;
					end
				end
				S_FCHK: begin
					if (!bm_rdata_q.head[ROW_IW'(lo_q)]) begin
						done_q    <= 1'b1;
						status_q  <= ST_UNKNOWN;
						granted_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						hi_q       <= AW'(32'(lo_q) + 32'(len_rdata_q) - 1);
						fill_q     <= 1'b1;
						mark_row_q <= row_of(lo_q);
						state_q    <= S_MARK;
					end
				end
				S_MARK: begin
					if (mark_last) begin
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						granted_q <= fill_q ? '0 : GRANT_W'(lo_q);
						state_q   <= S_IDLE;
					end else begin
						mark_row_q <= mark_row_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign granted_start = granted_q;

endmodule

// File: tb/first_fit_allocator_tb.sv
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Sends allocate and free requests through the start/busy handshake.
// A bitmap shadow of the heap predicts each reply, and the reply is checked
// field by field on the done strobe. A short directed run covers zero size,
// oversize, whole-heap, double free and merging of freed runs. Random traffic
// follows, mostly frees of live blocks and small allocations, under several
// sender idling phases.
// ----------------------------------------------------------------------------
module first_fit_allocator_tb;

	import ffa_pkg::*;

	localparam int HEAP         = HEAP_UNITS_DEF;
	localparam int RANDOM_ITEMS = 1880;
	localparam int DRAIN        = 300;
	localparam int LIMIT        = 1000000;
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [REQ_W-1:0]   units;
		logic [START_W-1:0] base;
	} request_t;

	typedef struct packed {
		status_t            status;
		logic [GRANT_W-1:0] start;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               kind = 1'b0;
	logic [REQ_W-1:0]   request_units = '0;
	logic [START_W-1:0] block_start = '0;
	logic               done;
	status_t            status;
	logic [GRANT_W-1:0] granted_start;

	request_t pending_items[$];
	reply_t   awaited_replies[$];

	bit                 free_map [HEAP];
	bit                 head_map [HEAP];
	logic [LEN_W-1:0]   len_map  [HEAP];
	int                 used_units = 0;
	int                 replies_by_status [4];
	int                 accepted_items = 0;
	int                 mismatches = 0;
	int                 idle_pct = 0;
	int                 cycles = 0;

	first_fit_allocator #(.HEAP_UNITS(HEAP)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.request_units (request_units),
		.block_start   (block_start),
		.done          (done),
		.status        (status),
		.granted_start (granted_start)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Timeout after %0d cycles, %0d replies outstanding", cycles,
				awaited_replies.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void serve_request(input logic k, input logic [REQ_W-1:0] want,
			input logic [START_W-1:0] base);
		reply_t r;
		int     run_start;
		int     run_len;
		bit     found;
		r.status = ST_OK;
		r.start = '0;
		if (k == KIND_ALLOC) begin
			if (want == 0) begin
				r.status = ST_ZERO;
			end else if (int'(want) > HEAP) begin
				r.status = ST_NO_FIT;
			end else begin
				found = 1'b0;
				run_start = 0;
				run_len = 0;
				for (int i = 0; i < HEAP && !found; i++) begin
					if (free_map[i]) begin
						if (run_len == 0)
							run_start = i;
						run_len++;
						if (run_len == int'(want))
							found = 1'b1;
					end else begin
						run_len = 0;
					end
				end
				if (found) begin
					for (int j = run_start; j < run_start + int'(want); j++)
						free_map[j] = 1'b0;
					head_map[run_start] = 1'b1;
					len_map[run_start] = want;
					used_units += int'(want);
					r.start = run_start[GRANT_W-1:0];
				end else begin
					r.status = ST_NO_FIT;
				end
			end
		end else begin
			if (int'(base) >= HEAP || !head_map[base]) begin
				r.status = ST_UNKNOWN;
			end else begin
				head_map[base] = 1'b0;
				for (int j = int'(base); j < int'(base) + int'(len_map[base]) && j < HEAP; j++)
					free_map[j] = 1'b1;
				used_units -= int'(len_map[base]);
			end
		end
		replies_by_status[r.status]++;
		awaited_replies.push_back(r);
	endfunction

	function automatic int pick_live();
		int s;
		s = $urandom_range(HEAP - 1);
		for (int j = 0; j < HEAP; j++)
			if (head_map[(s + j) % HEAP])
				return (s + j) % HEAP;
		return -1;
	endfunction

	task automatic queue_request(input logic k, input int units, input int base);
		request_t rq;
		rq.kind = k;
		rq.units = units[REQ_W-1:0];
		rq.base = base[START_W-1:0];
		pending_items.push_back(rq);
	endtask

	task automatic note_mismatch(input string what, input reply_t exp_r);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch (%s) at cycle %0d: expected status %0d start %0d, got status %0d start %0d",
				what, cycles, exp_r.status, exp_r.start, status, granted_start);
	endtask

	always @(posedge clk or negedge arst_n) begin : request_driver
		request_t nxt;
		logic     took;
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_ALLOC;
			request_units <= '0;
			block_start <= '0;
		end else begin
			took = start && !busy;
			if (took) begin
				serve_request(kind, request_units, block_start);
				accepted_items++;
			end
			if (!start || took) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_items.pop_front();
					start <= 1'b1;
					kind <= nxt.kind;
					request_units <= nxt.units;
					block_start <= nxt.base;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : reply_monitor
		reply_t exp_r;
		if (arst_n && done) begin
			if (awaited_replies.size() == 0) begin
				exp_r = '0;
				note_mismatch("reply with no request outstanding", exp_r);
			end else begin
				exp_r = awaited_replies.pop_front();
				if (status !== exp_r.status || granted_start !== exp_r.start)
					note_mismatch("wrong reply", exp_r);
			end
		end
	end

	initial begin : stimulus
		int r;
		int live;
		int units;
		int free_pct;
		for (int i = 0; i < HEAP; i++)
			free_map[i] = 1'b1;

		queue_request(KIND_ALLOC, 0, 1023);
		queue_request(KIND_ALLOC, 1025, 0);
		queue_request(KIND_ALLOC, 2047, 1023);
		queue_request(KIND_ALLOC, 1024, 0);
		queue_request(KIND_ALLOC, 1, 0);
		queue_request(KIND_FREE, 2047, 0);
		queue_request(KIND_FREE, 0, 0);
		queue_request(KIND_ALLOC, 1, 0);
		queue_request(KIND_ALLOC, 15, 0);
		queue_request(KIND_ALLOC, 16, 0);
		queue_request(KIND_ALLOC, 17, 0);
		queue_request(KIND_FREE, 0, 5);
		queue_request(KIND_FREE, 0, 1);
		queue_request(KIND_ALLOC, 16, 0);
		queue_request(KIND_FREE, 0, 16);
		queue_request(KIND_ALLOC, 31, 0);
		queue_request(KIND_FREE, 0, 1023);
		queue_request(KIND_ALLOC, 959, 0);
		queue_request(KIND_FREE, 0, 65);
		queue_request(KIND_FREE, 0, 32);
		queue_request(KIND_ALLOC, 1, 0);
		queue_request(KIND_FREE, 0, 0);
		queue_request(KIND_FREE, 0, 1);
		queue_request(KIND_FREE, 0, 32);
		queue_request(KIND_FREE, 0, 49);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			@(negedge clk);
			while (pending_items.size() != 0)
				@(negedge clk);
			if (n < RANDOM_ITEMS / 4)
				idle_pct = 0;
			else if (n < RANDOM_ITEMS / 2)
				idle_pct = 61;
			else if (n < 3 * RANDOM_ITEMS / 4)
				idle_pct = 0;
			else
				idle_pct = 21;
			free_pct = (used_units > 3 * HEAP / 4) ? 70 : 45;
			if ($urandom_range(99) < free_pct) begin
				live = pick_live();
				if (live < 0 || $urandom_range(99) < 15)
					live = $urandom_range(HEAP - 1);
				queue_request(KIND_FREE, $urandom_range(2047), live);
			end else begin
				r = $urandom_range(99);
				if (r < 70)
					units = $urandom_range(16, 1);
				else if (r < 88)
					units = $urandom_range(128, 17);
				else if (r < 96)
					units = $urandom_range(600, 129);
				else if (r < 98)
					units = $urandom_range(1024, 601);
				else if (r < 99)
					units = 0;
				else
					units = $urandom_range(2047, 1025);
				queue_request(KIND_ALLOC, units, $urandom_range(HEAP - 1));
			end
		end

		while (pending_items.size() != 0 || start)
			@(negedge clk);
		while (awaited_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("Covered %0d requests: %0d ok, %0d no fit, %0d unknown start, %0d zero size",
			accepted_items, replies_by_status[ST_OK], replies_by_status[ST_NO_FIT],
			replies_by_status[ST_UNKNOWN], replies_by_status[ST_ZERO]);
		$display("Idling phases: none, sender 61 in 100, none, sender 21 in 100; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/ffa_pkg.sv
sv/first_fit_allocator.sv
tb/first_fit_allocator_tb.sv
